@@ hdl/crc8prf_pkg.sv @@
// ----------------------------------------------------------------------------
// crc8prf_pkg
// shared types, constants and the crc-8 step for the framed packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package crc8prf_pkg;

   localparam logic [7:0] START_UNICAST   = 8'd72;
   localparam logic [7:0] START_MULTICAST = 8'd138;
   localparam logic [7:0] CRC_POLY        = 8'h07;
   localparam logic [7:0] LENGTH_INDEX    = 8'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_MCAST_OK   = 3'd1,
      ST_UCAST_OK   = 3'd2,
      ST_BAD_CRC    = 3'd3,
      ST_OTHER_ADDR = 3'd4,
      ST_BAD_START  = 3'd5,
      ST_TIMEOUT    = 3'd6
   } status_type;

   typedef enum logic {
      REG_NODE_ADDRESS  = 1'b0,
      REG_TIMEOUT_TICKS = 1'b1
   } reg_index_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       addr_hi_match;
      logic       addr_lo_match;
      logic       start_ucast;
      logic       start_mcast;
   } event_type;

   typedef struct packed {
      logic       strobe;
      logic [7:0] value;
      logic [7:0] index;
      logic       pkt_end;
      status_type status;
      logic       receiving;
   } result_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

@@ hdl/crc8prf_front.sv @@
// ----------------------------------------------------------------------------
// crc8prf_front
// input stage: takes words and tags them with start and address matches
// ----------------------------------------------------------------------------
`default_nettype none

module crc8prf_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire crc8prf_pkg::cmd_type   in_cmd,
   input  wire logic [7:0]             in_data,
   input  wire logic [15:0]            node_address,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output crc8prf_pkg::event_type      out_event
);
   import crc8prf_pkg::*;

   logic      ev_valid_ff;
   logic      ev_valid_in;
   event_type ev_ff;
   event_type ev_in;
   logic      take;

   assign in_ready = !ev_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      ev_in.cmd           = in_cmd;
      ev_in.data          = in_data;
      ev_in.addr_hi_match = (in_data == node_address[15:8]);
      ev_in.addr_lo_match = (in_data == node_address[7:0]);
      ev_in.start_ucast   = (in_data == START_UNICAST);
      ev_in.start_mcast   = (in_data == START_MULTICAST);
      if (take) begin
         ev_valid_in = 1'b1;
      end else if (out_ready) begin
         ev_valid_in = 1'b0;
      end else begin
         ev_valid_in = ev_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ev_ff <= ev_in;
      end
   end

   assign out_valid = ev_valid_ff;
   assign out_event = ev_ff;

endmodule

`default_nettype wire

@@ hdl/crc8prf_queue.sv @@
// ----------------------------------------------------------------------------
// crc8prf_queue
// short fifo of tagged words between the front and back stages
// ----------------------------------------------------------------------------
`default_nettype none

module crc8prf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire crc8prf_pkg::event_type push_data,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output crc8prf_pkg::event_type      pop_data
);
   import crc8prf_pkg::*;

   event_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/crc8prf_back.sv @@
// ----------------------------------------------------------------------------
// crc8prf_back
// packet state, crc, classification, timeout and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module crc8prf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ev_valid,
   output logic                        ev_ready,
   input  wire crc8prf_pkg::event_type ev,
   input  wire logic [7:0]             timeout_ticks,
   output logic                        res_valid,
   input  wire logic                   res_ready,
   output crc8prf_pkg::result_type     res
);
   import crc8prf_pkg::*;

   logic [7:0] pos_ff,  pos_in;
   logic [7:0] crc_ff,  crc_in;
   logic [7:0] flen_ff, flen_in;
   logic       ucast_ff, ucast_in;
   logic       mcast_ff, mcast_in;
   logic       ahi_ff,  ahi_in;
   logic       alo_ff,  alo_in;
   logic       armed_ff, armed_in;
   logic [7:0] ticks_ff, ticks_in;
   logic       res_valid_ff, res_valid_in;
   result_type res_ff, res_in;
   logic [7:0] flen_eff;
   logic       in_body;
   logic       crc_ok;
   logic       take;

   assign ev_ready = !res_valid_ff || res_ready;
   assign take     = ev_valid && ev_ready;

   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      flen_in  = flen_ff;
      ucast_in = ucast_ff;
      mcast_in = mcast_ff;
      ahi_in   = ahi_ff;
      alo_in   = alo_ff;
      armed_in = armed_ff;
      ticks_in = ticks_ff;
      flen_eff = (pos_ff == LENGTH_INDEX) ? ev.data : flen_ff;
      in_body  = (pos_ff < LENGTH_INDEX) || (pos_ff < flen_eff);
      crc_ok   = (crc_ff == ev.data);
      res_in.strobe    = 1'b0;
      res_in.value     = '0;
      res_in.index     = '0;
      res_in.pkt_end   = 1'b0;
      res_in.status    = ST_NONE;
      res_in.receiving = armed_ff;
      case (ev.cmd)
         CMD_BYTE: begin
            res_in.strobe = 1'b1;
            res_in.value  = ev.data;
            res_in.index  = pos_ff;
            ticks_in      = '0;
            flen_in       = flen_eff;
            if (in_body) begin
               if (pos_ff == 8'd0) begin
                  ucast_in = ev.start_ucast;
                  mcast_in = ev.start_mcast;
               end
               if (pos_ff == 8'd1) begin
                  ahi_in = ev.addr_hi_match;
               end
               if (pos_ff == 8'd2) begin
                  alo_in = ev.addr_lo_match;
               end
               crc_in           = crc8_update(crc_ff, ev.data);
               pos_in           = pos_ff + 8'd1;
               armed_in         = 1'b1;
               res_in.receiving = 1'b1;
            end else begin
               res_in.pkt_end = 1'b1;
               if (mcast_ff && crc_ok) begin
                  res_in.status = ST_MCAST_OK;
               end else if (ucast_ff && crc_ok && ahi_ff && alo_ff) begin
                  res_in.status = ST_UCAST_OK;
               end else if (!ucast_ff && !mcast_ff) begin
                  res_in.status = ST_BAD_START;
               end else if (!crc_ok) begin
                  res_in.status = ST_BAD_CRC;
               end else begin
                  res_in.status = ST_OTHER_ADDR;
               end
               pos_in           = '0;
               crc_in           = '0;
               armed_in         = 1'b0;
               res_in.receiving = 1'b0;
            end
         end
         CMD_TICK: begin
            if (armed_ff) begin
               if (ticks_ff >= timeout_ticks) begin
                  res_in.pkt_end   = 1'b1;
                  res_in.status    = ST_TIMEOUT;
                  res_in.receiving = 1'b0;
                  pos_in           = '0;
                  crc_in           = '0;
                  armed_in         = 1'b0;
                  ticks_in         = '0;
               end else begin
                  ticks_in = ticks_ff + 8'd1;
               end
            end
         end
         default: begin
            res_in.receiving = armed_ff;
         end
      endcase
      if (take) begin
         res_valid_in = 1'b1;
      end else if (res_ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= '0;
         flen_ff      <= '0;
         ucast_ff     <= 1'b0;
         mcast_ff     <= 1'b0;
         ahi_ff       <= 1'b0;
         alo_ff       <= 1'b0;
         armed_ff     <= 1'b0;
         ticks_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (take) begin
            pos_ff   <= pos_in;
            crc_ff   <= crc_in;
            flen_ff  <= flen_in;
            ucast_ff <= ucast_in;
            mcast_ff <= mcast_in;
            ahi_ff   <= ahi_in;
            alo_ff   <= alo_in;
            armed_ff <= armed_in;
            ticks_ff <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

`default_nettype wire

@@ hdl/crc8_packet_receiver_filter_unit.sv @@
// ----------------------------------------------------------------------------
// crc8_packet_receiver_filter_unit
// framed packet receiver with crc-8 check, address filter and tick timeout
// ----------------------------------------------------------------------------
// req channel: one word per received byte (tuser 0) or timer tick (tuser 1),
// tdata carries the byte. rsp channel: exactly one word per req word, in
// order: the byte with its index and a strobe, and at the checksum byte or a
// timeout a word with tlast high and the packet status in tuser[3:1].
// csr channel: index 0 writes the 16-bit node address, index 1 the 8-bit
// timeout tick count; it is always ready, and the user must write it only while
// the block is idle; the block itself does not enforce this.
// path: a req word passes the input register, a queue entry and the result
// register in that order before it reaches the rsp channel; throughput one word
// per cycle while rsp_tready is high, set by the combinational crc byte step and
// classification in the back stage.
// reset clears the packet state, the queue and both valid flags; node address
// resets to 0 and the timeout to 1. when rsp_tready is low the result
// register holds, the queue fills, then req_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_packet_receiver_filter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] byte_value, [15:8] byte_index, [16] receiving
   output logic [3:0]       rsp_tuser,   // [0] byte_strobe, [3:1] packet_status
   output logic             rsp_tlast,   // packet_end
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);
   import crc8prf_pkg::*;

   logic [15:0] node_address_ff;
   logic [7:0]  timeout_ticks_ff;
   logic        fe_valid;
   logic        fe_ready;
   event_type   fe_event;
   logic        q_valid;
   logic        q_ready;
   event_type   q_event;
   result_type  res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff  <= '0;
         timeout_ticks_ff <= 8'd1;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_NODE_ADDRESS:  node_address_ff  <= csr_data;
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_data[7:0];
            default:           node_address_ff  <= node_address_ff;
         endcase
      end
   end

   crc8prf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_cmd       (cmd_type'(req_tuser)),
      .in_data      (req_tdata),
      .node_address (node_address_ff),
      .out_valid    (fe_valid),
      .out_ready    (fe_ready),
      .out_event    (fe_event)
   );

   crc8prf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_data  (fe_event),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_event)
   );

   crc8prf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .ev_valid      (q_valid),
      .ev_ready      (q_ready),
      .ev            (q_event),
      .timeout_ticks (timeout_ticks_ff),
      .res_valid     (rsp_tvalid),
      .res_ready     (rsp_tready),
      .res           (res)
   );

   assign rsp_tdata = {7'd0, res.receiving, res.index, res.value};
   assign rsp_tuser = {res.status, res.strobe};
   assign rsp_tlast = res.pkt_end;

   a_end_has_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser[3:1] != ST_NONE)))
      else $error("packet end and status disagree");

   a_end_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !rsp_tdata[16])
      else $error("still receiving after packet end");

   a_tick_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("byte fields set on a tick word");

   a_byte_end_not_timeout: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[3:1] != ST_TIMEOUT))
      else $error("timeout reported on a byte word");

endmodule

`default_nettype wire
